### rtl/sm4cbc_pkg.sv
// sm4cbc_pkg: constants, s-box table and round functions for the sm4 cbc cipher
// used by the round unit and the top level; no dependencies

package sm4cbc_pkg;

   localparam int unsigned NumRoundsDefault = 32;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned HalfWidth = 64;
   localparam int unsigned CsrIndexWidth = 3;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_KEY_HIGH = 3'd0;
   localparam csr_index_type CSR_KEY_LOW = 3'd1;
   localparam csr_index_type CSR_IV_HIGH = 3'd2;
   localparam csr_index_type CSR_IV_LOW = 3'd3;
   localparam csr_index_type CSR_DECRYPT_MODE = 3'd4;

   localparam word_type FK0 = 32'ha3b1bac6;
   localparam word_type FK1 = 32'h56aa3350;
   localparam word_type FK2 = 32'h677d9197;
   localparam word_type FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic word_type rol(input word_type x, input int unsigned n);
      return (x << n) | (x >> (WordWidth - n));
   endfunction

   function automatic word_type subst(input word_type x);
      return {SBOX_TABLE[x[31:24]], SBOX_TABLE[x[23:16]],
              SBOX_TABLE[x[15:8]], SBOX_TABLE[x[7:0]]};
   endfunction

   function automatic word_type mix_data(input word_type x);
      return x ^ rol(x, 2) ^ rol(x, 10) ^ rol(x, 18) ^ rol(x, 24);
   endfunction

   function automatic word_type mix_key(input word_type x);
      return x ^ rol(x, 13) ^ rol(x, 23);
   endfunction

   // byte j of the constant for round r is ((4r + j) * 7) mod 256
   function automatic word_type ck_word(input logic [7:0] r);
      word_type w;
      logic [7:0] b;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         b = {r[5:0], 2'b00} + 8'(j);
         w = {w[23:0], 8'((b << 3) - b)};
      end
      return w;
   endfunction

endpackage

### rtl/sm4cbc_if.sv
// sm4cbc_req_if and sm4cbc_rsp_if: valid/ready channels for requests and results
// depends on sm4cbc_pkg

interface sm4cbc_req_if
   import sm4cbc_pkg::*;
   ();
   logic valid;
   logic ready;
   half_type block_high;
   half_type block_low;
   logic new_message;

   modport source (output valid, block_high, block_low, new_message, input ready);
   modport sink (input valid, block_high, block_low, new_message, output ready);
endinterface

interface sm4cbc_rsp_if
   import sm4cbc_pkg::*;
   ();
   logic valid;
   logic ready;
   half_type out_high;
   half_type out_low;

   modport source (output valid, out_high, out_low, input ready);
   modport sink (input valid, out_high, out_low, output ready);
endinterface

### rtl/sm4cbc_ram.sv
// sm4cbc_ram: generic single write port ram with registered read
// no dependencies

module sm4cbc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sm4cbc_round.sv
// sm4cbc_round: shared sm4 round function for key expansion and data rounds
// depends on sm4cbc_pkg

module sm4cbc_round
   import sm4cbc_pkg::*;
(
   input  logic     key_sched,
   input  word_type w0,
   input  word_type w1,
   input  word_type w2,
   input  word_type w3,
   input  word_type rk,
   output word_type result
);

   word_type t;

   always_comb begin
      t = subst(w1 ^ w2 ^ w3 ^ rk);
      result = w0 ^ (key_sched ? mix_key(t) : mix_data(t));
   end

endmodule

### rtl/sm4cbc_top_stub.sv
// sm4cbc_seq: word shift register fed by the round unit that it instantiates
// depends on sm4cbc_pkg and sm4cbc_round

module sm4cbc_seq
   import sm4cbc_pkg::*;
(
   input  logic                          clock,
   input  logic                          load,
   input  logic [4*WordWidth-1:0]        load_data,
   input  logic                          step,
   input  logic                          key_sched,
   input  word_type                      rk,
   output logic [4*WordWidth-1:0]        words,
   output word_type                      new_word
);

   word_type w_ff [4];
   word_type w_in [4];

   sm4cbc_round u_round (
      .key_sched (key_sched),
      .w0        (w_ff[0]),
      .w1        (w_ff[1]),
      .w2        (w_ff[2]),
      .w3        (w_ff[3]),
      .rk        (rk),
      .result    (new_word)
   );

   always_comb begin
      w_in = w_ff;
      if (load) begin
         w_in[0] = load_data[127:96];
         w_in[1] = load_data[95:64];
         w_in[2] = load_data[63:32];
         w_in[3] = load_data[31:0];
      end else if (step) begin
         w_in[0] = w_ff[1];
         w_in[1] = w_ff[2];
         w_in[2] = w_ff[3];
         w_in[3] = new_word;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   // after the last round the words read back in reverse order
   assign words = {w_ff[3], w_ff[2], w_ff[1], w_ff[0]};

endmodule

### rtl/sm4_cbc_block_cipher.sv
// sm4_cbc_block_cipher: sm4-128 cbc block cipher, one 128-bit block per request
// depends on sm4cbc_pkg, sm4cbc_if, sm4cbc_ram, sm4cbc_seq
//
// usage: key, iv and decrypt_mode are written over the csr port while the block
// is idle. each request carries one 128-bit block; new_message restarts the chain
// from the iv and expands the round keys again. each request gives one result.
// sequence: a request without key expansion goes through a load step, the rounds
// (one round per cycle through the shared round unit) and a chaining step before
// its result is valid; a message start, or the first request after reset, first
// runs the key expansion rounds on the same round unit.
// a new request is taken only once the previous one has left the rounds and the
// chaining step; req_chan.ready is high only while no request is in progress.
// the result sits in an output register: a new request is taken while it waits,
// but the chaining cycle holds until the receiver takes the previous result.
// reset clears the csr registers, the chain and the key-valid flag, so the first
// request always expands the key. round keys live in a ram with no reset.

module sm4_cbc_block_cipher
   import sm4cbc_pkg::*;
#(
   parameter int unsigned NUM_ROUNDS = NumRoundsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   sm4cbc_req_if.sink           req_chan,
   sm4cbc_rsp_if.source         rsp_chan,
   input  logic                 csr_write_enable,
   input  csr_index_type        csr_index,
   input  half_type             csr_write_data
);

   localparam int unsigned CntWidth = $clog2(NUM_ROUNDS);
   localparam logic [CntWidth-1:0] LastRound = CntWidth'(NUM_ROUNDS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PREP,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic keys_valid_ff, keys_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] out_ff, out_in;

   half_type key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic decrypt_mode_ff;

   logic accept;
   logic seq_load, seq_step, key_sched;
   logic [127:0] seq_load_data, words, result;
   word_type new_word, rk, rk_rd;
   logic [CntWidth-1:0] rd_addr, cnt_next;
   logic ram_wr;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         iv_high_ff <= '0;
         iv_low_ff <= '0;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            CSR_KEY_LOW: key_low_ff <= csr_write_data;
            CSR_IV_HIGH: iv_high_ff <= csr_write_data;
            CSR_IV_LOW: iv_low_ff <= csr_write_data;
            CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && (state_ff == ST_IDLE);

   assign key_sched = (state_ff == ST_EXPAND);
   assign ram_wr = (state_ff == ST_EXPAND);
   assign rk = key_sched ? ck_word(8'(cnt_ff)) : rk_rd;
   assign cnt_next = cnt_ff + 1'b1;
   assign result = decrypt_mode_ff ? (words ^ chain_ff) : words;

   always_comb begin
      if (state_ff == ST_PREP) begin
         rd_addr = decrypt_mode_ff ? LastRound : '0;
      end else begin
         rd_addr = decrypt_mode_ff ? LastRound - cnt_next : cnt_next;
      end
   end

   sm4cbc_ram #(
      .WIDTH (WordWidth),
      .DEPTH (NUM_ROUNDS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (cnt_ff),
      .wr_data (new_word),
      .rd_addr (rd_addr),
      .rd_data (rk_rd)
   );

   sm4cbc_seq u_seq (
      .clock     (clock),
      .load      (seq_load),
      .load_data (seq_load_data),
      .step      (seq_step),
      .key_sched (key_sched),
      .rk        (rk),
      .words     (words),
      .new_word  (new_word)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      keys_valid_in = keys_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      blk_in = blk_ff;
      chain_in = chain_ff;
      out_in = out_ff;
      seq_load = 1'b0;
      seq_step = 1'b0;
      seq_load_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               blk_in = {req_chan.block_high, req_chan.block_low};
               cnt_in = '0;
               if (req_chan.new_message || !keys_valid_ff) begin
                  seq_load = 1'b1;
                  seq_load_data = {key_high_ff ^ {FK0, FK1}, key_low_ff ^ {FK2, FK3}};
                  chain_in = {iv_high_ff, iv_low_ff};
                  keys_valid_in = 1'b1;
                  state_in = ST_EXPAND;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_EXPAND: begin
            seq_step = 1'b1;
            cnt_in = cnt_next;
            if (cnt_ff == LastRound) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            seq_load = 1'b1;
            seq_load_data = decrypt_mode_ff ? blk_ff : (blk_ff ^ chain_ff);
            cnt_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            seq_step = 1'b1;
            cnt_in = cnt_next;
            if (cnt_ff == LastRound) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_in = result;
               rsp_valid_in = 1'b1;
               chain_in = decrypt_mode_ff ? blk_ff : words;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         keys_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         keys_valid_ff <= keys_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff <= chain_in;
      end
      blk_ff <= blk_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_high = out_ff[127:64];
   assign rsp_chan.out_low = out_ff[63:0];

endmodule
